[rtl/kcc_pkg.sv]
`timescale 1ns / 1ps
package kcc_pkg;

	// opcodes of the request channel
	localparam logic [1:0] OP_SCAN  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 15;
	localparam logic [CFG_IDX_W-1:0] CFG_FILTER_TIME   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_TIME     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW = 2'd2;

	// configuration reset values
	localparam logic [7:0]  FILTER_TIME_RST   = 8'd5;
	localparam logic [14:0] LONG_TIME_RST     = 15'd100;
	localparam logic [7:0]  DOUBLE_WINDOW_RST = 8'd50;

	// press counter starts at half of the reset filter time
	localparam logic [15:0] PRESS_CNT_RST = 16'(FILTER_TIME_RST / 2);
	localparam logic [15:0] PRESS_CNT_MAX = 16'hFFFF;
	localparam logic [8:0]  TIMER_MAX     = 9'd511;

	// key states
	localparam logic [1:0] KS_NONE   = 2'd0;
	localparam logic [1:0] KS_SHORT  = 2'd1;
	localparam logic [1:0] KS_LONG   = 2'd2;
	localparam logic [1:0] KS_DOUBLE = 2'd3;

	// event code offsets, code = 4 * key + offset
	localparam logic [5:0] EV_SHORT  = 6'd3;
	localparam logic [5:0] EV_LONG   = 6'd4;
	localparam logic [5:0] EV_DOUBLE = 6'd5;

	typedef enum logic [1:0] {
		CMD_SCAN,
		CMD_POP,
		CMD_CLEAR,
		CMD_NOP
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] key_pressed;
		logic [2:0] key_index;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  filter_time;
		logic [14:0] long_time;
		logic [7:0]  double_window;
	} cfg_t;

endpackage

[rtl/kcc_in_if.sv]
`timescale 1ns / 1ps
interface kcc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [7:0] key_pressed;
	logic [2:0] key_index;

	modport source (output valid, opcode, key_pressed, key_index, input ready);
	modport sink (input valid, opcode, key_pressed, key_index, output ready);
endinterface

[rtl/kcc_out_if.sv]
`timescale 1ns / 1ps
interface kcc_out_if;
	logic       valid;
	logic       ready;
	logic [5:0] event_code;
	logic       code_valid;
	logic [1:0] key_state;

	modport source (output valid, event_code, code_valid, key_state, input ready);
	modport sink (input valid, event_code, code_valid, key_state, output ready);
endinterface

[rtl/key_click_classifier_fifo_unit.sv]
`timescale 1ns / 1ps
// Key click classifier with an event code queue.
// req channel (valid/ready): opcode, key_pressed, key_index. A scan
// transaction walks the keys and classifies long presses, double clicks and
// single short presses, pushing event codes 4k+4, 4k+5, 4k+3 into a ring
// queue of QUEUE_DEPTH entries that overwrites on overrun. A pop transaction
// returns the oldest code, a clear transaction empties the queue.
// rsp channel (valid/ready): one transaction per request with event_code,
// code_valid and the state of key key_index after the request.
// Configuration: cfg_we, cfg_index and cfg_data write filter_time (0),
// long_time (1) and double_window (2); write them only while idle.
// A request passes through the command queue; a scan then walks the keys
// one key per cycle on the shared classifier, and each result is loaded
// into the output register. The back end takes no new request until its
// result is loaded; the front accepts up to two more requests meanwhile.
// Reset restores all key state, clears the queue pointers, the command queue and the
// result valid; configuration returns to 5, 100 and 50. When rsp is stalled
// the result holds, the back end waits and the front fills and then drops req.ready.
module key_click_classifier_fifo_unit
	import kcc_pkg::*;
#(
	parameter int KEYS        = 4,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	kcc_in_if.sink                req,
	kcc_out_if.source             rsp,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t cfg_q;
	cmd_t cmd;
	logic cmd_valid;
	logic cmd_ready;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.filter_time   <= FILTER_TIME_RST;
			cfg_q.long_time     <= LONG_TIME_RST;
			cfg_q.double_window <= DOUBLE_WINDOW_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FILTER_TIME:   cfg_q.filter_time   <= cfg_data[7:0];
				CFG_LONG_TIME:     cfg_q.long_time     <= cfg_data[14:0];
				CFG_DOUBLE_WINDOW: cfg_q.double_window <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	kcc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready)
	);

	kcc_back #(
		.KEYS        (KEYS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.rsp       (rsp)
	);

endmodule

[rtl/kcc_front.sv]
`timescale 1ns / 1ps
module kcc_front
	import kcc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	kcc_in_if.sink    req,
	output cmd_t      cmd,
	output logic      cmd_valid,
	input  logic      cmd_ready
);

	cmd_t       q_mem_q [2];
	logic       head_q;
	logic [1:0] cnt_q;
	logic       tail;
	logic       push;
	logic       pop;
	cmd_t       new_cmd;

	// classify the opcode into a command
	always_comb begin
		new_cmd.key_pressed = req.key_pressed;
		new_cmd.key_index   = req.key_index;
		unique case (req.opcode)
			OP_SCAN:  new_cmd.kind = CMD_SCAN;
			OP_POP:   new_cmd.kind = CMD_POP;
			OP_CLEAR: new_cmd.kind = CMD_CLEAR;
			default:  new_cmd.kind = CMD_NOP;
		endcase
	end

	// two-entry command queue
	assign req.ready = (cnt_q != 2'd2);
	assign push      = req.valid && req.ready;
	assign cmd_valid = (cnt_q != 2'd0);
	assign pop       = cmd_valid && cmd_ready;
	assign cmd       = q_mem_q[head_q];
	assign tail      = head_q ^ cnt_q[0];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[tail] <= new_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (pop) begin
				head_q <= ~head_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[rtl/kcc_back.sv]
`timescale 1ns / 1ps
module kcc_back
	import kcc_pkg::*;
#(
	parameter int KEYS        = 4,
	parameter int QUEUE_DEPTH = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  cmd_t      cmd,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	kcc_out_if.source rsp
);

	localparam int KW = (KEYS > 1) ? $clog2(KEYS) : 1;
	localparam int PW = $clog2(QUEUE_DEPTH);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_DONE = 3'b100
	} state_t;

	state_t         state_q;
	logic [KW-1:0]  kcnt_q;
	logic [7:0]     pressed_q;
	logic [2:0]     idx_q;
	logic           pop_hit_q;
	logic [5:0]     rd_data_q;

	// per-key state
	logic [15:0]    pcnt_q  [KEYS];
	logic [1:0]     pst_q   [KEYS];
	logic           sflag_q [KEYS];
	logic           dflag_q [KEYS];
	logic [8:0]     dtim_q  [KEYS];

	// event queue
	logic [5:0]     store_q [QUEUE_DEPTH];
	logic [PW-1:0]  rp_q;
	logic [PW-1:0]  wp_q;

	// output register
	logic           out_valid_q;
	logic [5:0]     out_code_q;
	logic           out_cvalid_q;
	logic [1:0]     out_state_q;

	logic [KW-1:0]  addr;
	logic [15:0]    pc;
	logic [15:0]    pc_inc;
	logic [15:0]    f16;
	logic [15:0]    f2;
	logic [15:0]    c_long;
	logic           s_long;
	logic [8:0]     tim;
	logic [15:0]    n_pc;
	logic [1:0]     n_st;
	logic           n_sf;
	logic           n_df;
	logic [8:0]     n_tim;
	logic           ev_push;
	logic [5:0]     ev_code;
	logic [5:0]     key_base;
	logic           down;
	logic           take;
	logic           pop_take;
	logic           out_load;
	logic [1:0]     sel_state;

	assign cmd_ready = (state_q == S_IDLE);
	assign take      = cmd_valid && cmd_ready;
	assign pop_take  = take && (cmd.kind == CMD_POP) && (rp_q != wp_q);
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// one read port on the key state: walking key or reported key
	assign addr      = (state_q == S_SCAN) ? kcnt_q : idx_q[KW-1:0];
	assign sel_state = ({1'b0, idx_q} < 4'(KEYS)) ? pst_q[addr] : KS_NONE;

	// classification of the key at the walk position
	assign pc       = pcnt_q[addr];
	assign pc_inc   = (pc != PRESS_CNT_MAX) ? pc + 16'd1 : pc;
	assign f16      = {8'd0, cfg.filter_time};
	assign f2       = {7'd0, cfg.filter_time, 1'b0};
	assign tim      = (dtim_q[addr] != TIMER_MAX) ? dtim_q[addr] + 9'd1 : dtim_q[addr];
	assign down     = pressed_q[kcnt_q];
	assign key_base = {4'(kcnt_q), 2'b00};

	always_comb begin
		n_pc    = pc;
		n_st    = pst_q[addr];
		n_sf    = sflag_q[addr];
		n_df    = dflag_q[addr];
		n_tim   = tim;
		ev_push = 1'b0;
		ev_code = key_base + EV_SHORT;
		c_long  = pc_inc;
		s_long  = sflag_q[addr];
		if (down) begin
			if (pc < f16) begin
				n_pc = f16;
			end else if (pc < f2) begin
				n_pc = pc_inc;
			end else begin
				// first pass past the filter arms the short flag
				if (!sflag_q[addr]) begin
					s_long = 1'b1;
					c_long = 16'd0;
				end
				if (c_long > {1'b0, cfg.long_time}) begin
					n_st    = KS_LONG;
					s_long  = 1'b0;
					c_long  = 16'd0;
					ev_push = 1'b1;
					ev_code = key_base + EV_LONG;
				end
				n_pc = c_long;
				n_sf = s_long;
			end
		end else if (sflag_q[addr] && (pst_q[addr] != KS_LONG)) begin
			// release after a short press
			n_sf = 1'b0;
			if (!dflag_q[addr]) begin
				n_df  = 1'b1;
				n_tim = 9'd0;
			end else if (tim < {1'b0, cfg.double_window}) begin
				n_df    = 1'b0;
				n_st    = KS_DOUBLE;
				ev_push = 1'b1;
				ev_code = key_base + EV_DOUBLE;
			end
		end else begin
			// idle key: single press once the window has run out
			if (dflag_q[addr] && (tim > {1'b0, cfg.double_window})) begin
				n_df    = 1'b0;
				ev_push = 1'b1;
				ev_code = key_base + EV_SHORT;
			end
			n_sf = 1'b0;
			n_st = KS_NONE;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			kcnt_q    <= '0;
			pop_hit_q <= 1'b0;
			rp_q      <= '0;
			wp_q      <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (take) begin
						kcnt_q    <= '0;
						pop_hit_q <= pop_take;
						if (pop_take) begin
							rp_q <= (rp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_q + PW'(1);
						end
						if (cmd.kind == CMD_CLEAR) begin
							rp_q <= wp_q;
						end
						state_q <= (cmd.kind == CMD_SCAN) ? S_SCAN : S_DONE;
					end
				end
				S_SCAN: begin
					if (ev_push) begin
						wp_q <= (wp_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_q + PW'(1);
					end
					if (kcnt_q == KW'(KEYS - 1)) begin
						state_q <= S_DONE;
					end else begin
						kcnt_q <= kcnt_q + KW'(1);
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// command payload
	always_ff @(posedge clk) begin
		if (take) begin
			pressed_q <= cmd.key_pressed;
			idx_q     <= cmd.key_index;
		end
	end

	// key state write-back, one key per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEYS; k++) begin
				pcnt_q[k]  <= PRESS_CNT_RST;
				pst_q[k]   <= KS_NONE;
				sflag_q[k] <= 1'b0;
				dflag_q[k] <= 1'b0;
				dtim_q[k]  <= 9'd0;
			end
		end else if (state_q == S_SCAN) begin
			pcnt_q[kcnt_q]  <= n_pc;
			pst_q[kcnt_q]   <= n_st;
			sflag_q[kcnt_q] <= n_sf;
			dflag_q[kcnt_q] <= n_df;
			dtim_q[kcnt_q]  <= n_tim;
		end
	end

	// event queue memory
	always_ff @(posedge clk) begin
		if ((state_q == S_SCAN) && ev_push) begin
			store_q[wp_q] <= ev_code;
		end
		if (pop_take) begin
			rd_data_q <= store_q[rp_q];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_code_q   <= pop_hit_q ? rd_data_q : 6'd0;
			out_cvalid_q <= pop_hit_q;
			out_state_q  <= sel_state;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.event_code = out_code_q;
	assign rsp.code_valid = out_cvalid_q;
	assign rsp.key_state  = out_state_q;

endmodule

[rtl/kcc_checker.sv]
`timescale 1ns / 1ps
module kcc_checker
	import kcc_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [5:0] event_code,
	input logic       code_valid,
	input logic [1:0] key_state
);

	// a returned code is always a real event code
	a_code_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && code_valid |-> event_code != 6'd0)
		else $error("popped event code is zero");

	// no code without a successful pop
	a_code_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !code_valid |-> event_code == 6'd0)
		else $error("event code set without code_valid");

	// the key state never reads short
	a_no_short: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> key_state != KS_SHORT)
		else $error("key state reads short");

	// stalled result transaction holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(event_code)
			&& $stable(code_valid) && $stable(key_state))
		else $error("result changed while stalled");

endmodule

bind key_click_classifier_fifo_unit kcc_checker u_kcc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.event_code (rsp.event_code),
	.code_valid (rsp.code_valid),
	.key_state  (rsp.key_state)
);
